### rtl/stereo_cross_feedback_delay_fade_core_defines.svh
// Assertion macros shared by the delay core.
`ifndef STEREO_CROSS_FEEDBACK_DELAY_FADE_CORE_DEFINES_SVH
`define STEREO_CROSS_FEEDBACK_DELAY_FADE_CORE_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define SCFD_ASSERT_IMP(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define SCFD_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scfd_pkg;
  localparam int unsigned CfgCount = 7;
  localparam int unsigned TimeBits = 23;
  localparam int unsigned GainBits = 16;
  localparam int unsigned DryWetBits = 15;
  localparam int unsigned AddrBits = 5;
  localparam logic signed [15:0] Q14One = 16'sd16384;

  typedef enum logic [2:0] {
    RegDryWet = 3'd0,
    RegDelayLeft = 3'd1,
    RegDelayRight = 3'd2,
    RegFbLeft = 3'd3,
    RegFbRight = 3'd4,
    RegCrossLr = 3'd5,
    RegCrossRl = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [DryWetBits-1:0] dry_wet;
    logic [TimeBits-1:0] delay_left_target;
    logic [TimeBits-1:0] delay_right_target;
    logic signed [GainBits-1:0] feedback_left;
    logic signed [GainBits-1:0] feedback_right;
    logic signed [GainBits-1:0] cross_left_to_right;
    logic signed [GainBits-1:0] cross_right_to_left;
  } cfg_t;

  function automatic logic signed [GainBits-1:0] clamp_gain(
    input logic signed [GainBits-1:0] g
  );
    logic signed [GainBits-1:0] r;
    r = g;
    if (g > Q14One) r = Q14One;
    if (g < -Q14One) r = -Q14One;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/scfd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface scfd_stream_if #(
  parameter int unsigned SampleBits = 24
);
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] left;
  logic signed [SampleBits-1:0] right;
  modport source (output valid, output left, output right, input ready);
  modport sink (input valid, input left, input right, output ready);
endinterface
`default_nettype wire

### rtl/scfd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module scfd_cfg_regs (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [scfd_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output scfd_pkg::cfg_t cfg_o
);
  import scfd_pkg::*;
  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;
  assign idx = paddr[AddrBits-1:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dry_wet: DryWetBits'(16384), default: '0};
    end else if (wr) begin
      case (idx)
        RegDryWet: cfg_q.dry_wet <= pwdata[DryWetBits-1:0];
        RegDelayLeft: cfg_q.delay_left_target <= pwdata[TimeBits-1:0];
        RegDelayRight: cfg_q.delay_right_target <= pwdata[TimeBits-1:0];
        RegFbLeft: cfg_q.feedback_left <= pwdata[GainBits-1:0];
        RegFbRight: cfg_q.feedback_right <= pwdata[GainBits-1:0];
        RegCrossLr: cfg_q.cross_left_to_right <= pwdata[GainBits-1:0];
        RegCrossRl: cfg_q.cross_right_to_left <= pwdata[GainBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDryWet: prdata = 32'(cfg_q.dry_wet);
      RegDelayLeft: prdata = 32'(cfg_q.delay_left_target);
      RegDelayRight: prdata = 32'(cfg_q.delay_right_target);
      RegFbLeft: prdata = 32'(cfg_q.feedback_left);
      RegFbRight: prdata = 32'(cfg_q.feedback_right);
      RegCrossLr: prdata = 32'(cfg_q.cross_left_to_right);
      RegCrossRl: prdata = 32'(cfg_q.cross_right_to_left);
      default: prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/scfd_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// One channel: delay memory, four serialized reads, interpolation, crossfade,
// feedback write. Sequenced by the top-level phase counter.
module scfd_channel #(
  parameter int unsigned DelayDepth = 32768,
  parameter int unsigned FadeLength = 256,
  parameter int unsigned SampleBits = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [3:0] phase_i,
  input  wire logic [$clog2(DelayDepth)-1:0] wpos_i,
  input  wire logic [$clog2(FadeLength)-1:0] fade_i,
  input  wire logic [scfd_pkg::TimeBits-1:0] t_now_i,
  input  wire logic [scfd_pkg::TimeBits-1:0] t_coming_i,
  input  wire logic signed [SampleBits-1:0] in_i,
  input  wire logic signed [SampleBits-1:0] other_last_i,
  input  wire logic signed [scfd_pkg::GainBits-1:0] fb_i,
  input  wire logic signed [scfd_pkg::GainBits-1:0] cross_i,
  input  wire logic [scfd_pkg::DryWetBits-1:0] dw_i,
  output logic signed [SampleBits-1:0] wet_o,
  output logic signed [SampleBits-1:0] out_o
);
  import scfd_pkg::*;
  localparam int unsigned AW = $clog2(DelayDepth);
  localparam int unsigned FW = $clog2(FadeLength);
  localparam int unsigned SW = SampleBits;
  localparam int unsigned IW = (TimeBits - 8 > AW) ? TimeBits - 8 : AW;
  localparam logic [IW-1:0] IpLim = IW'(DelayDepth - 1);
  localparam logic signed [SW+1:0] SMax = (SW+2)'((64'd1 << (SW - 1)) - 1);
  localparam logic signed [SW+1:0] SMin = -SMax - 1;

  logic signed [SW-1:0] mem [DelayDepth];
  logic signed [SW-1:0] rd_q;
  logic [AW-1:0] raddr;
  logic we;
  logic signed [SW-1:0] wdata;

  logic signed [SW-1:0] s0_q, c_q, n_q;
  logic [7:0] fr_now, fr_coming, fr;
  logic signed [SW:0] wet_q;
  logic signed [SW-1:0] wet_sat;
  logic signed [SW-1:0] out_q, wb_sat;

  function automatic logic [AW-1:0] tap_addr(input logic [TimeBits-1:0] t,
                                             input logic one_more);
    logic [IW-1:0] ip;
    logic [AW-1:0] a;
    ip = IW'(t[TimeBits-1:8]);
    if (ip >= IpLim) ip = IpLim;
    a = wpos_i - AW'(1) - AW'(ip);
    if (one_more) a = a - AW'(1);
    return a;
  endfunction

  function automatic logic [7:0] tap_frac(input logic [TimeBits-1:0] t);
    if (IW'(t[TimeBits-1:8]) >= IpLim) return 8'd0;
    return t[7:0];
  endfunction

  function automatic logic signed [SW+1:0] sat(input logic signed [SW+1:0] v);
    if (v > SMax) return SMax;
    if (v < SMin) return SMin;
    return v;
  endfunction

  assign fr_now = tap_frac(t_now_i);
  assign fr_coming = tap_frac(t_coming_i);

  // read order: now s0, now s1, coming s0, coming s1
  always_comb begin
    case (phase_i)
      4'd0: raddr = tap_addr(t_now_i, 1'b0);
      4'd1: raddr = tap_addr(t_now_i, 1'b1);
      4'd2: raddr = tap_addr(t_coming_i, 1'b0);
      default: raddr = tap_addr(t_coming_i, 1'b1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (we) mem[wpos_i] <= wdata;
  end

  // interpolation of the sample read in the previous cycle
  logic signed [SW:0] diff;
  logic signed [SW+9:0] prod;
  logic signed [SW:0] tapv;
  assign fr = (phase_i == 4'd2) ? fr_now : fr_coming;
  assign diff = (SW+1)'(rd_q) - (SW+1)'(s0_q);
  assign prod = (SW+10)'(diff) * $signed({2'b0, fr});
  assign tapv = (SW+1)'(s0_q) + (SW+1)'(prod >>> 8);

  // crossfade
  logic signed [SW+1:0] fdiff;
  logic signed [SW+FW+2:0] fprod;
  assign fdiff = (SW+2)'(n_q) - (SW+2)'(c_q);
  assign fprod = (SW+FW+3)'(fdiff) * $signed({1'b0, fade_i});

  // feedback write value and output mix
  logic signed [SW+GainBits+2:0] acc;
  logic signed [SW+GainBits+1:0] mix;
  logic signed [GainBits-1:0] fbg, crg;
  logic [DryWetBits-1:0] dwc;
  assign fbg = clamp_gain(fb_i);
  assign crg = clamp_gain(cross_i);
  assign dwc = (dw_i > DryWetBits'(16384)) ? DryWetBits'(16384) : dw_i;
  assign acc = ((SW+GainBits+3)'(in_i) <<< 14)
             + (SW+GainBits+3)'(other_last_i) * (SW+GainBits+3)'(crg)
             + (SW+GainBits+3)'(wet_sat) * (SW+GainBits+3)'(fbg);
  assign mix = ((SW+GainBits+2)'(wet_sat) - (SW+GainBits+2)'(in_i))
             * $signed({1'b0, dwc});

  assign wet_sat = SW'(wet_q);
  assign we = (phase_i == 4'd6);
  assign wdata = SW'(sat((SW+2)'(wb_sat)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      c_q <= '0;
      n_q <= '0;
      wet_q <= '0;
    end else begin
      case (phase_i)
        4'd1: s0_q <= rd_q;
        4'd2: c_q <= SW'(tapv);
        4'd3: s0_q <= rd_q;
        4'd4: n_q <= SW'(tapv);
        4'd5: wet_q <= (SW+1)'((SW+FW+3)'(c_q) + (fprod >>> FW));
        default: ;
      endcase
    end
  end

  // write value: floor of the Q14 sum, saturated to the sample range
  logic signed [SW+GainBits+2:0] wbv;
  assign wbv = acc >>> 14;
  assign wb_sat = SW'(wbv > (SW+GainBits+3)'(SMax) ? SMax :
                     (wbv < (SW+GainBits+3)'(SMin) ? SMin : (SW+2)'(wbv)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (phase_i == 4'd6) begin
      out_q <= SW'(sat((SW+2)'((SW+GainBits+2)'(in_i) + (mix >>> 14))));
    end
  end

  assign wet_o = wet_sat;
  assign out_o = out_q;
endmodule
`default_nettype wire

### rtl/stereo_cross_feedback_delay_fade_core.sv
`timescale 1ns / 1ps
`default_nettype none
// One frame at a time: seven read/compute/write phases on each channel's
// one-read one-write delay memory, an output load (held while the last result
// is not taken), and the idle state that takes the next request.
// Reset: control, fade times and last outputs clear; memory contents clear
// by a sweep over all DelayDepth addresses after reset, during which no input
// is taken.
module stereo_cross_feedback_delay_fade_core #(
  parameter int unsigned DelayDepth = 32768,
  parameter int unsigned FadeLength = 256,
  parameter int unsigned SampleBits = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scfd_stream_if.sink in_i,
  scfd_stream_if.source out_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [scfd_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import scfd_pkg::*;
  `include "stereo_cross_feedback_delay_fade_core_defines.svh"
  localparam int unsigned AW = $clog2(DelayDepth);
  localparam int unsigned FW = $clog2(FadeLength);
  localparam int unsigned SW = SampleBits;

  typedef enum logic [1:0] {StClear, StIdle, StRun, StOut} state_e;
  state_e state_q;
  logic [3:0] phase_q;
  logic [AW-1:0] wpos_q;
  logic [FW-1:0] fade_q;
  logic [TimeBits-1:0] ltn_q, ltc_q, rtn_q, rtc_q;
  logic signed [SW-1:0] lin_q, rin_q, llast_q, rlast_q;
  logic signed [SW-1:0] lwet, rwet, lout, rout;
  logic signed [SW-1:0] lout_q, rout_q;
  logic ovalid_q;
  logic out_load;
  cfg_t cfg;

  scfd_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // clear sweep drives write phase with zero input and zero gains
  logic clearing;
  logic [3:0] ph;
  assign clearing = (state_q == StClear);
  assign ph = clearing ? 4'd6 : phase_q;

  scfd_channel #(.DelayDepth(DelayDepth), .FadeLength(FadeLength),
                 .SampleBits(SampleBits)) u_left (
    .clk_i, .rst_ni, .phase_i(ph), .wpos_i(wpos_q), .fade_i(fade_q),
    .t_now_i(ltn_q), .t_coming_i(ltc_q),
    .in_i(clearing ? '0 : lin_q), .other_last_i(clearing ? '0 : rlast_q),
    .fb_i(clearing ? '0 : cfg.feedback_left),
    .cross_i(clearing ? '0 : cfg.cross_right_to_left),
    .dw_i(cfg.dry_wet), .wet_o(lwet), .out_o(lout)
  );
  scfd_channel #(.DelayDepth(DelayDepth), .FadeLength(FadeLength),
                 .SampleBits(SampleBits)) u_right (
    .clk_i, .rst_ni, .phase_i(ph), .wpos_i(wpos_q), .fade_i(fade_q),
    .t_now_i(rtn_q), .t_coming_i(rtc_q),
    .in_i(clearing ? '0 : rin_q), .other_last_i(clearing ? '0 : llast_q),
    .fb_i(clearing ? '0 : cfg.feedback_right),
    .cross_i(clearing ? '0 : cfg.cross_left_to_right),
    .dw_i(cfg.dry_wet), .wet_o(rwet), .out_o(rout)
  );

  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.left = lout_q;
  assign out_o.right = rout_q;
  assign out_load = (state_q == StOut) && (!ovalid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      phase_q <= '0;
      wpos_q <= '0;
      fade_q <= '0;
      ltn_q <= '0; ltc_q <= '0; rtn_q <= '0; rtc_q <= '0;
      lin_q <= '0; rin_q <= '0;
      llast_q <= '0; rlast_q <= '0;
      lout_q <= '0; rout_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        StClear: begin
          wpos_q <= wpos_q + AW'(1);
          if (wpos_q == AW'(DelayDepth - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_i.valid) begin
            lin_q <= in_i.left;
            rin_q <= in_i.right;
            phase_q <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          phase_q <= phase_q + 4'd1;
          if (phase_q == 4'd6) begin
            llast_q <= lwet;
            rlast_q <= rwet;
            wpos_q <= wpos_q + AW'(1);
            if (fade_q == FW'(FadeLength - 1)) begin
              fade_q <= '0;
              ltn_q <= ltc_q; ltc_q <= cfg.delay_left_target;
              rtn_q <= rtc_q; rtc_q <= cfg.delay_right_target;
            end else begin
              fade_q <= fade_q + FW'(1);
            end
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_load) begin
            lout_q <= lout;
            rout_q <= rout;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `SCFD_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, !in_i.ready,
    "input taken while busy")
  `SCFD_ASSERT_NEXT(a_wpos_step, clk_i, rst_ni, state_q == StRun && phase_q == 4'd6,
    wpos_q == $past(wpos_q) + AW'(1), "write position did not advance")
  `SCFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
    out_o.valid, "result dropped")
endmodule
`default_nettype wire

### tb/tb_stereo_cross_feedback_delay_fade_core.sv
`timescale 1ns / 1ps
module tb_stereo_cross_feedback_delay_fade_core;
  import scfd_pkg::*;

  localparam int unsigned Depth = 32768;
  localparam int unsigned FadeLen = 256;
  localparam longint SampleMax = 8388607;
  localparam longint SampleMin = -8388608;
  localparam longint QOne = 16384;
  localparam int unsigned IdleLimit = 200000;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scfd_stream_if #(.SampleBits(24)) in_if ();
  scfd_stream_if #(.SampleBits(24)) out_if ();

  stereo_cross_feedback_delay_fade_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if.sink),
    .out_o(out_if.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.left = '0;
    in_if.right = '0;
    out_if.ready = 1'b0;
  end

  // predictor state
  cfg_t mix_cfg;
  logic signed [23:0] left_line [Depth];
  logic signed [23:0] right_line [Depth];
  int unsigned wr_pos;
  longint prev_left_wet, prev_right_wet;
  int unsigned fade_pos;
  logic [TimeBits-1:0] l_now, l_next, r_now, r_next;
  frame_t mix_queue[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > SampleMax) return SampleMax;
    if (v < SampleMin) return SampleMin;
    return v;
  endfunction

  function automatic longint bounded_gain(logic signed [GainBits-1:0] g);
    longint v;
    v = g;
    if (v > QOne) v = QOne;
    if (v < -QOne) v = -QOne;
    return v;
  endfunction

  function automatic longint read_tap(bit right_side, logic [TimeBits-1:0] t);
    longint tt, ip, fr, s0, s1;
    int unsigned i0, i1;
    tt = t;
    if (tt > longint'(Depth - 1) * 256) tt = longint'(Depth - 1) * 256;
    ip = tt >> 8;
    fr = tt & 255;
    i0 = 32'((wr_pos + Depth - 1 - ip) % Depth);
    i1 = 32'((wr_pos + 2 * Depth - 2 - ip) % Depth);
    s0 = right_side ? right_line[i0] : left_line[i0];
    s1 = right_side ? right_line[i1] : left_line[i1];
    return s0 + floor_div((s1 - s0) * fr, 256);
  endfunction

  function automatic longint faded_tap(bit right_side, logic [TimeBits-1:0] now_t,
                                       logic [TimeBits-1:0] next_t);
    longint c, n;
    c = read_tap(right_side, now_t);
    n = read_tap(right_side, next_t);
    return c + floor_div((n - c) * fade_pos, FadeLen);
  endfunction

  function automatic frame_t mix_frame(frame_t f);
    longint l, r, dw, wl, wr;
    frame_t o;
    l = f.left;
    r = f.right;
    dw = mix_cfg.dry_wet;
    if (dw > QOne) dw = QOne;
    wl = faded_tap(1'b0, l_now, l_next);
    wr = faded_tap(1'b1, r_now, r_next);
    left_line[wr_pos] = 24'(clip_sample(floor_div(l * QOne
        + prev_right_wet * bounded_gain(mix_cfg.cross_right_to_left)
        + wl * bounded_gain(mix_cfg.feedback_left), QOne)));
    right_line[wr_pos] = 24'(clip_sample(floor_div(r * QOne
        + prev_left_wet * bounded_gain(mix_cfg.cross_left_to_right)
        + wr * bounded_gain(mix_cfg.feedback_right), QOne)));
    wr_pos = (wr_pos + 1) % Depth;
    prev_left_wet = wl;
    prev_right_wet = wr;
    o.left = 24'(clip_sample(l + floor_div((wl - l) * dw, QOne)));
    o.right = 24'(clip_sample(r + floor_div((wr - r) * dw, QOne)));
    if (fade_pos + 1 >= FadeLen) begin
      fade_pos = 0;
      l_now = l_next;
      l_next = mix_cfg.delay_left_target;
      r_now = r_next;
      r_next = mix_cfg.delay_right_target;
    end else begin
      fade_pos++;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrBits'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDryWet: mix_cfg.dry_wet = val[DryWetBits-1:0];
      RegDelayLeft: mix_cfg.delay_left_target = val[TimeBits-1:0];
      RegDelayRight: mix_cfg.delay_right_target = val[TimeBits-1:0];
      RegFbLeft: mix_cfg.feedback_left = val[GainBits-1:0];
      RegFbRight: mix_cfg.feedback_right = val[GainBits-1:0];
      RegCrossLr: mix_cfg.cross_left_to_right = val[GainBits-1:0];
      default: mix_cfg.cross_right_to_left = val[GainBits-1:0];
    endcase
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (mix_queue.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // valid stays high after a request until the next request, an idle gap before it, or a drain drops it
  task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_t f;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    f.left = l;
    f.right = r;
    in_if.valid <= 1'b1;
    in_if.left <= l;
    in_if.right <= r;
    do @(posedge clk_i); while (!in_if.ready);
    mix_queue.push_back(mix_frame(f));
  endtask

  function automatic logic [31:0] rand_gain();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return 32'(16'sd16384);
    if (k == 1) return 32'(-16'sd16384);
    if (k == 2) return 32'($urandom_range(65535));
    return 32'(16'($urandom_range(16000)) - 16'd8000);
  endfunction

  // output side: stall and check
  always @(posedge clk_i) begin
    frame_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (mix_queue.size() == 0) begin
          report_mismatch("unexpected frame", out_if.left, 0);
        end else begin
          want = mix_queue.pop_front();
          if (out_if.left !== want.left) report_mismatch("left_out", out_if.left, want.left);
          if (out_if.right !== want.right)
            report_mismatch("right_out", out_if.right, want.right);
        end
      end
      out_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: reset sweep clears the memory first, so allow for it
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_stereo_cross_feedback_delay_fade_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    logic signed [23:0] ext [4];
    ext = '{24'sh7fffff, 24'sh800000, 24'sd0, -24'sd1};
    write_reg(RegDryWet, 32'd16384);
    write_reg(RegDelayLeft, 32'd0);
    write_reg(RegDelayRight, 32'd128);
    write_reg(RegFbLeft, 32'(16'sd16384));
    write_reg(RegFbRight, 32'(-16'sd16384));
    write_reg(RegCrossLr, 32'(16'sh7fff));
    write_reg(RegCrossRl, 32'(16'sh8000));
    foreach (ext[i]) foreach (ext[j]) send_frame(ext[i], ext[j]);
    wait_drained();
    // dry only, over-range dry_wet, and very long delays saturated
    write_reg(RegDryWet, 32'd0);
    send_frame(24'sh123456, -24'sh654321);
    wait_drained();
    write_reg(RegDryWet, 32'h7fff);
    write_reg(RegDelayLeft, 32'h7fffff);
    write_reg(RegDelayRight, 32'd8388352);
    repeat (8) send_frame(24'($urandom), 24'($urandom));
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned n);
    int unsigned k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(RegDryWet, $urandom_range(3) == 0 ? 32'($urandom_range(32767))
                                                : 32'($urandom_range(16384)));
    // mostly short delays so the taps see written data
    write_reg(RegDelayLeft, $urandom_range(3) == 0 ? 32'($urandom_range(8388607))
                                                   : 32'($urandom_range(600 * 256)));
    write_reg(RegDelayRight, $urandom_range(3) == 0 ? 32'($urandom_range(8388607))
                                                    : 32'($urandom_range(600 * 256)));
    write_reg(RegFbLeft, rand_gain());
    write_reg(RegFbRight, rand_gain());
    write_reg(RegCrossLr, rand_gain());
    write_reg(RegCrossRl, rand_gain());
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        send_frame($urandom_range(1) ? 24'sh7fffff : 24'sh800000,
                   $urandom_range(1) ? 24'sh7fffff : 24'sh800000);
      end else begin
        send_frame(24'($urandom), 24'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    mix_cfg = '0;
    mix_cfg.dry_wet = 15'd16384;
    foreach (left_line[i]) begin
      left_line[i] = '0;
      right_line[i] = '0;
    end
    wr_pos = 0;
    prev_left_wet = 0;
    prev_right_wet = 0;
    fade_pos = 0;
    l_now = '0;
    l_next = '0;
    r_now = '0;
    r_next = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(0, 0, 300);
    test_random_phase(58, 0, 300);
    test_random_phase(0, 58, 300);
    test_random_phase(30, 30, 300);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_stereo_cross_feedback_delay_fade_core passed");
    end else begin
      $display("tb_stereo_cross_feedback_delay_fade_core failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/scfd_pkg.sv
rtl/scfd_stream_if.sv
rtl/scfd_cfg_regs.sv
rtl/scfd_channel.sv
rtl/stereo_cross_feedback_delay_fade_core.sv
tb/tb_stereo_cross_feedback_delay_fade_core.sv
